### sv/overscan_bias_correction_defines.svh
// assertion macros for the overscan bias correction block
// no dependencies; included by the modules that check their own logic
`ifndef OVERSCAN_BIAS_CORRECTION_DEFINES_SVH
`define OVERSCAN_BIAS_CORRECTION_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OVB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OVB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define OVB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define OVB_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### sv/ovb_pkg.sv
// shared constants and types for the overscan bias correction block
// no dependencies
`timescale 1ns / 1ps

package ovb_pkg;

   localparam int OVERSCAN_PIXELS_DEF = 16;
   localparam int MAX_WIDTH_DEF       = 4096;

   localparam int PIXEL_W   = 16;
   localparam int AVG_W     = PIXEL_W + 1;  // odd overscan count can average above full scale
   localparam int WIDTH_W   = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIDTH_W-1:0] ACTIVE_WIDTH_RESET = 13'd1264;
   localparam logic [PIXEL_W-1:0] PEDESTAL_RESET     = 16'd1000;

   // register index, taken from paddr[2]
   localparam logic REG_ACTIVE_WIDTH = 1'b0;
   localparam logic REG_PEDESTAL     = 1'b1;

   // control from the line sequencer to the overscan accumulator
   typedef struct packed {
      logic sample_en;   // an overscan word is being taken
      logic clear;       // first overscan word of a line
      logic odd_parity;  // word belongs to the odd column sum
   } acc_ctrl_type;

endpackage

### sv/ovb_bias_acc.sv
// overscan accumulator: per-parity sums and their averages
// depends on ovb_pkg
`timescale 1ns / 1ps

module ovb_bias_acc #(
   parameter int OVERSCAN_PIXELS = ovb_pkg::OVERSCAN_PIXELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ovb_pkg::acc_ctrl_type          ctrl,
   input  logic [ovb_pkg::PIXEL_W-1:0]    raw_pixel,
   output logic [ovb_pkg::AVG_W-1:0]      odd_avg,
   output logic [ovb_pkg::AVG_W-1:0]      even_avg
);

   localparam int DIVISOR   = OVERSCAN_PIXELS / 2;
   localparam int ODD_COUNT = (OVERSCAN_PIXELS + 1) / 2;
   localparam int SUM_W     = ovb_pkg::PIXEL_W + $clog2(ODD_COUNT);
   localparam int DIV_L     = $clog2(DIVISOR);
   localparam int SHIFT     = SUM_W + DIV_L;
   localparam int RECIP_W   = SUM_W + 2;
   localparam int PROD_W    = SUM_W + RECIP_W;
   // ceil(2^SHIFT / DIVISOR): exact floor division for every sum below 2^SUM_W
   localparam logic [RECIP_W-1:0] RECIP_C =
      RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [SUM_W-1:0]            odd_sum_ff, odd_sum_in;
   logic [SUM_W-1:0]            even_sum_ff, even_sum_in;
   logic [PROD_W-1:0]           odd_prod, even_prod;
   logic [ovb_pkg::AVG_W-1:0]   odd_avg_ff, odd_avg_in;
   logic [ovb_pkg::AVG_W-1:0]   even_avg_ff, even_avg_in;

   always_comb begin
      odd_sum_in  = odd_sum_ff;
      even_sum_in = even_sum_ff;
      if (ctrl.sample_en) begin
         if (ctrl.clear) begin
            odd_sum_in  = '0;
            even_sum_in = '0;
         end
         if (ctrl.odd_parity) begin
            odd_sum_in = odd_sum_in + SUM_W'(raw_pixel);
         end else begin
            even_sum_in = even_sum_in + SUM_W'(raw_pixel);
         end
      end
   end

   // divide by reciprocal multiply on the incoming sum, so each average is registered together with its sum
   assign odd_prod    = PROD_W'(odd_sum_in) * PROD_W'(RECIP_C);
   assign even_prod   = PROD_W'(even_sum_in) * PROD_W'(RECIP_C);
   assign odd_avg_in  = ovb_pkg::AVG_W'(odd_prod >> SHIFT);
   assign even_avg_in = ovb_pkg::AVG_W'(even_prod >> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_sum_ff  <= '0;
         even_sum_ff <= '0;
         odd_avg_ff  <= '0;
         even_avg_ff <= '0;
      end else begin
         odd_sum_ff  <= odd_sum_in;
         even_sum_ff <= even_sum_in;
         odd_avg_ff  <= odd_avg_in;
         even_avg_ff <= even_avg_in;
      end
   end

   assign odd_avg  = odd_avg_ff;
   assign even_avg = even_avg_ff;

endmodule

### sv/overscan_bias_correction.sv
// top level of the overscan bias correction block: line sequencer, clamp, csr port
// depends on ovb_pkg, ovb_bias_acc and overscan_bias_correction_defines.svh
`timescale 1ns / 1ps
`include "overscan_bias_correction_defines.svh"

//  channel | ports                                   | moves
//  --------+-----------------------------------------+------------------------------
//  req     | req_valid req_ready req_raw_pixel       | one raw sensor word
//  rsp     | rsp_valid rsp_ready rsp_pixel_out/_end  | one corrected word, line flag
//  csr     | psel penable pwrite paddr pwdata ...    | active_width @0, pedestal @4
//
//  one word per clock in both directions; an active word shows on rsp in the cycle
//  after it is taken, set by the single output register
//  overscan words are absorbed and give no rsp word
//  req_ready drops only while the output register holds a word that rsp stalls
//  synchronous active-high reset: start of line, sums cleared, csr defaults
//  no clearing pass after reset, words are taken on the first cycle

module overscan_bias_correction #(
   parameter int OVERSCAN_PIXELS = ovb_pkg::OVERSCAN_PIXELS_DEF,
   parameter int MAX_WIDTH       = ovb_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ovb_pkg::PIXEL_W-1:0]       req_raw_pixel,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ovb_pkg::PIXEL_W-1:0]       rsp_pixel_out,
   output logic                              rsp_line_end,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ovb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ovb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ovb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   // column counter spans overscan plus the widest line
   localparam int POS_W = $clog2(OVERSCAN_PIXELS + MAX_WIDTH);
   localparam int CMP_W = (POS_W > ovb_pkg::WIDTH_W) ? POS_W : ovb_pkg::WIDTH_W;
   localparam int DIFF_W = ovb_pkg::PIXEL_W + 3;

   // csr registers
   logic [ovb_pkg::WIDTH_W-1:0]  active_width_ff;
   logic [ovb_pkg::PIXEL_W-1:0]  pedestal_ff;
   logic                         csr_write;

   // line sequencer
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [POS_W-1:0]             active_idx;
   logic [CMP_W-1:0]             width_ext, last_idx;
   logic                         in_overscan;
   logic                         req_fire;
   logic                         line_end_in;
   ovb_pkg::acc_ctrl_type        acc_ctrl;

   // correction datapath
   logic [ovb_pkg::AVG_W-1:0]    odd_avg, even_avg, avg_sel;
   logic signed [DIFF_W-1:0]     diff;
   logic [ovb_pkg::PIXEL_W-1:0]  pixel_in;

   // output register
   logic                         rsp_valid_ff;
   logic [ovb_pkg::PIXEL_W-1:0]  pixel_ff;
   logic                         line_end_ff;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff <= ovb_pkg::ACTIVE_WIDTH_RESET;
         pedestal_ff     <= ovb_pkg::PEDESTAL_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            ovb_pkg::REG_ACTIVE_WIDTH: begin
               active_width_ff <= pwdata[ovb_pkg::WIDTH_W-1:0];
            end
            ovb_pkg::REG_PEDESTAL: begin
               pedestal_ff <= pwdata[ovb_pkg::PIXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         ovb_pkg::REG_ACTIVE_WIDTH: prdata = ovb_pkg::CSR_DATA_W'(active_width_ff);
         ovb_pkg::REG_PEDESTAL:     prdata = ovb_pkg::CSR_DATA_W'(pedestal_ff);
         default:                   prdata = '0;
      endcase
   end

   // ----------------------------------------------------------- line sequencer
   // input stalls only while a finished word waits downstream
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign in_overscan = pos_ff < POS_W'(OVERSCAN_PIXELS);
   assign active_idx  = pos_ff - POS_W'(OVERSCAN_PIXELS);

   // last active index: zero width acts as one, oversize saturates
   assign width_ext = CMP_W'(active_width_ff);
   always_comb begin
      if (width_ext == '0) begin
         last_idx = '0;
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         last_idx = CMP_W'(MAX_WIDTH - 1);
      end else begin
         last_idx = width_ext - CMP_W'(1);
      end
   end

   // reaching or passing the last index ends the line, also after a width change
   assign line_end_in = CMP_W'(active_idx) >= last_idx;

   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         if (!in_overscan && line_end_in) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // even overscan positions feed the odd-column sum, odd column first
   assign acc_ctrl.sample_en  = req_fire && in_overscan;
   assign acc_ctrl.clear      = (pos_ff == '0);
   assign acc_ctrl.odd_parity = !pos_ff[0];

   ovb_bias_acc #(
      .OVERSCAN_PIXELS (OVERSCAN_PIXELS)
   ) u_bias_acc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .raw_pixel (req_raw_pixel),
      .odd_avg   (odd_avg),
      .even_avg  (even_avg)
   );

   // ------------------------------------------------------ bias and clamp
   // active parity counts from the first active word, odd first
   assign avg_sel = !active_idx[0] ? odd_avg : even_avg;

   // raw - (avg - pedestal) as raw + pedestal - avg
   assign diff = $signed(DIFF_W'(req_raw_pixel)) + $signed(DIFF_W'(pedestal_ff))
               - $signed(DIFF_W'(avg_sel));

   always_comb begin
      if (diff[DIFF_W-1]) begin
         pixel_in = '0;
      end else if (diff[DIFF_W-2:ovb_pkg::PIXEL_W] != '0) begin
         pixel_in = '1;
      end else begin
         pixel_in = diff[ovb_pkg::PIXEL_W-1:0];
      end
   end

   // ------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && !in_overscan) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !in_overscan) begin
         pixel_ff    <= pixel_in;
         line_end_ff <= line_end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pixel_ff;
   assign rsp_line_end  = line_end_ff;

   // ---------------------------------------------------------------- checks
   `OVB_ASSERT_NXT(a_line_end_restarts, clock, reset,
      req_fire && !in_overscan && line_end_in, pos_ff == '0,
      "line end word did not restart the column counter")
   `OVB_ASSERT_NXT(a_active_word_loaded, clock, reset,
      req_fire && !in_overscan, rsp_valid_ff && (pixel_ff == $past(pixel_in)),
      "active word not loaded into the output register")
   `OVB_ASSERT_NXT(a_overscan_keeps_output, clock, reset,
      req_fire && in_overscan && rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(pixel_ff) && $stable(line_end_ff),
      "overscan word disturbed a stalled output word")
   `OVB_ASSERT_IMP(a_pos_in_range, clock, reset,
      1'b1, pos_ff <= POS_W'(OVERSCAN_PIXELS + MAX_WIDTH - 1),
      "column counter ran past the widest line")

endmodule
